/* sv/arp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg: shared types, constants and round function
// State word type, round constants, rotation amounts and the single-round
// transform used by every pipeline stage.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned MAX_ROUNDS = 12;
    localparam int unsigned ROUNDS_DEF = 6;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_state;

    // Round constants, bit-reversed, held in the top byte.
    localparam t_word RC [MAX_ROUNDS] = '{
        64'h0f00000000000000, 64'h8700000000000000,
        64'h4b00000000000000, 64'hc300000000000000,
        64'h2d00000000000000, 64'ha500000000000000,
        64'h6900000000000000, 64'he100000000000000,
        64'h1e00000000000000, 64'h9600000000000000,
        64'h5a00000000000000, 64'hd200000000000000
    };

    // Left rotation pair for each word of the linear layer.
    localparam int unsigned ROT_A [NUM_WORDS] = '{19, 61, 1, 10, 7};
    localparam int unsigned ROT_B [NUM_WORDS] = '{28, 39, 6, 17, 41};

    function automatic t_word arp_rotl(t_word v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // One round: constant addition, bitsliced S-box, linear diffusion.
    function automatic t_state arp_round(t_state s, t_word rc);
        t_word  a0, a1, a2, a3, a4;
        t_state t;
        t_state r;
        a0 = s[0];
        a1 = s[1];
        a2 = s[2] ^ rc;
        a3 = s[3];
        a4 = s[4];
        t[0] = (a4 & a1) ^ a3 ^ (a2 & a1) ^ a2 ^ (a1 & a0) ^ a1 ^ a0;
        t[1] = a4 ^ (a3 & a2) ^ (a3 & a1) ^ a3 ^ (a2 & a1) ^ a2 ^ a1 ^ a0;
        t[2] = ~((a4 & a3) ^ a4 ^ a2 ^ a1);
        t[3] = (a4 & a0) ^ a4 ^ (a3 & a0) ^ a3 ^ a2 ^ a1 ^ a0;
        t[4] = (a4 & a1) ^ a4 ^ a3 ^ (a1 & a0) ^ a1;
        for (int k = 0; k < NUM_WORDS; k++) begin
            r[k] = t[k] ^ arp_rotl(t[k], ROT_A[k]) ^ arp_rotl(t[k], ROT_B[k]);
        end
        return r;
    endfunction

endpackage

/* sv/arp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_if: valid/ready channels for the permutation
// Input channel carries the state before, output channel the state after.
// ----------------------------------------------------------------------------
interface arp_in_if import arp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word word0_in;
    t_word word1_in;
    t_word word2_in;
    t_word word3_in;
    t_word word4_in;

    modport source(output valid, output word0_in, output word1_in, output word2_in,
                   output word3_in, output word4_in, input ready);
    modport sink(input valid, input word0_in, input word1_in, input word2_in,
                 input word3_in, input word4_in, output ready);
endinterface

interface arp_out_if import arp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word word0_out;
    t_word word1_out;
    t_word word2_out;
    t_word word3_out;
    t_word word4_out;

    modport source(output valid, output word0_out, output word1_out, output word2_out,
                   output word3_out, output word4_out, input ready);
    modport sink(input valid, input word0_out, input word1_out, input word2_out,
                 input word3_out, input word4_out, output ready);
endinterface

/* sv/ascon_reduced_round_permutation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_reduced_round_permutation: pipelined reduced-round permutation
// One round per register stage; a new 320-bit state may enter every cycle unless a stall at o_out fills the pipeline.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                    | Handshake
//  --------+-----+----------------------------+-----------------
//  i_in    | in  | word0_in .. word4_in (64b) | valid / ready
//  o_out   | out | word0_out .. word4_out     | valid / ready
//
//  An accepted word moves through the stage registers in order and shows on
//  o_out from the last one, which hands it on while o_out.ready is high. Each
//  stage register holds the result of one round of S-box and diffusion.
//  Throughput is one word per cycle while o_out.ready stays high.
//  Synchronous active-low reset clears every stage valid bit; data is not reset.
//  A stall at o_out holds the last stage; stages behind it keep filling
//  bubbles, so i_in.ready drops only once every stage holds a word.
// ----------------------------------------------------------------------------
module ascon_reduced_round_permutation import arp_pkg::*; #(
    parameter int unsigned ROUNDS = ROUNDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    arp_in_if.sink       i_in,
    arp_out_if.source    o_out
);

    // Rounds beyond the constant table saturate.
    localparam int unsigned NSTAGE = (ROUNDS > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS;

    logic [NSTAGE-1:0] r_vld;
    t_state            r_st   [NSTAGE];
    t_state            n_st   [NSTAGE];
    logic [NSTAGE-1:0] w_up_vld;
    logic [NSTAGE:0]   w_rdy;

    t_state w_in_st;

    assign w_in_st = {i_in.word4_in, i_in.word3_in, i_in.word2_in,
                      i_in.word1_in, i_in.word0_in};

    // Ready ripples back: a stage takes a word when empty or when it moves on.
    assign w_rdy[NSTAGE] = o_out.ready;
    assign i_in.ready    = w_rdy[0];

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_up_vld[s] = i_in.valid;
            assign n_st[s]     = arp_round(w_in_st, RC[s]);
        end else begin : g_rest
            assign w_up_vld[s] = r_vld[s-1];
            assign n_st[s]     = arp_round(r_st[s-1], RC[s]);
        end

        assign w_rdy[s] = ~r_vld[s] | w_rdy[s+1];

        // Advance the valid bit; drop it when the word leaves with no successor.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_up_vld[s];
            end
        end

        // Load data only on a real transfer; otherwise hold.
        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_up_vld[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_out.valid     = r_vld[NSTAGE-1];
    assign o_out.word0_out = r_st[NSTAGE-1][0];
    assign o_out.word1_out = r_st[NSTAGE-1][1];
    assign o_out.word2_out = r_st[NSTAGE-1][2];
    assign o_out.word3_out = r_st[NSTAGE-1][3];
    assign o_out.word4_out = r_st[NSTAGE-1][4];

endmodule

/* sv/arp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_checker: port-level checks for the permutation pipeline
// Watches the handshakes of both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module arp_checker import arp_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_word i_word0,
    input t_word i_word1,
    input t_word i_word2,
    input t_word i_word3,
    input t_word i_word4
);

    // A stalled result stays offered.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_word0) && $stable(i_word1) && $stable(i_word2) &&
            $stable(i_word3) && $stable(i_word4))
        else $error("result changed while stalled");

    // Nothing is offered straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result offered after reset");

    // With the output draining, the pipeline never pushes back.
    a_no_false_stall: assert property (@(posedge i_clk)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

endmodule

bind ascon_reduced_round_permutation arp_checker u_arp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_word0     (o_out.word0_out),
    .i_word1     (o_out.word1_out),
    .i_word2     (o_out.word2_out),
    .i_word3     (o_out.word3_out),
    .i_word4     (o_out.word4_out)
);
